### design/q2r_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2r_pkg
// Shared constants for the quaternion to rotation matrix pipeline: the
// number of matrix entries and which of them lie on the diagonal.
// ----------------------------------------------------------------------------
package q2r_pkg;

   // Entries are numbered row by row: r00 r01 r02 r10 r11 r12 r20 r21 r22
   localparam int NUM_ENTRIES = 9;

   // Entry order inside every entry vector
   localparam int E00 = 0;
   localparam int E01 = 1;
   localparam int E02 = 2;
   localparam int E10 = 3;
   localparam int E11 = 4;
   localparam int E12 = 5;
   localparam int E20 = 6;
   localparam int E21 = 7;
   localparam int E22 = 8;

   // Diagonal entries are one minus a quotient, the others a signed quotient
   localparam logic [NUM_ENTRIES-1:0] DIAG_MASK = 9'b100010001;

endpackage

### design/q2r_terms.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2r_terms
// Two pipeline stages: the ten component products, then the squared norm
// and the nine numerators (magnitude plus sign) of the matrix entries.
// ----------------------------------------------------------------------------
module q2r_terms
   import q2r_pkg::*;
#(
   parameter int CB = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_stall,
   input  logic signed [CB-1:0]                 qx,
   input  logic signed [CB-1:0]                 qy,
   input  logic signed [CB-1:0]                 qz,
   input  logic signed [CB-1:0]                 qw,
   output logic                                 out_valid,
   input  logic                                 out_stall,
   output logic [NUM_ENTRIES-1:0][2*CB:0]       num,
   output logic [NUM_ENTRIES-1:0]               neg,
   output logic [2*CB:0]                        den,
   output logic                                 zero
);

   localparam int PW = 2 * CB;
   localparam int NB = 2 * CB + 1;

   logic st1, st2;
   logic v1_ff, v2_ff;
   logic zero1_ff, zero2_ff;
   logic signed [PW-1:0] xx_ff, yy_ff, zz_ff, ww_ff;
   logic signed [PW-1:0] xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;
   logic signed [PW-1:0] xx_in, yy_in, zz_in, ww_in;
   logic signed [PW-1:0] xy_in, wz_in, xz_in, wy_in, yz_in, wx_in;
   logic [NUM_ENTRIES-1:0][NB-1:0] num_ff, num_in;
   logic [NUM_ENTRIES-1:0] neg_ff, neg_in;
   logic [NB-1:0] den_ff, den_in;

   // Stall ripples back when a stage holds an item that cannot move on
   assign st2      = v2_ff && out_stall;
   assign st1      = v1_ff && st2;
   assign in_stall = st1;

   // Stage one: products
   always_comb begin
      xx_in = PW'(qx * qx);
      yy_in = PW'(qy * qy);
      zz_in = PW'(qz * qz);
      ww_in = PW'(qw * qw);
      xy_in = PW'(qx * qy);
      wz_in = PW'(qw * qz);
      xz_in = PW'(qx * qz);
      wy_in = PW'(qw * qy);
      yz_in = PW'(qy * qz);
      wx_in = PW'(qw * qx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (!st1) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!st1 && in_valid) begin
         xx_ff    <= xx_in;
         yy_ff    <= yy_in;
         zz_ff    <= zz_in;
         ww_ff    <= ww_in;
         xy_ff    <= xy_in;
         wz_ff    <= wz_in;
         xz_ff    <= xz_in;
         wy_ff    <= wy_in;
         yz_ff    <= yz_in;
         wx_ff    <= wx_in;
         zero1_ff <= (qx == '0) && (qy == '0) && (qz == '0) && (qw == '0);
      end
   end

   // Take magnitude and sign of a signed numerator
   function automatic logic [NB:0] split(input logic signed [NB-1:0] t);
      logic [NB-1:0] m;
      m = t[NB-1] ? NB'(-t) : NB'(t);
      return {t[NB-1], m};
   endfunction

   // Stage two: squared norm and numerators
   always_comb begin
      logic signed [NB-1:0] t1, t2, t3, t5, t6, t7;
      logic [NB:0] s1, s2, s3, s5, s6, s7;
      den_in = {1'b0, xx_ff} + {1'b0, yy_ff} + {1'b0, zz_ff} + {1'b0, ww_ff};
      t1 = NB'(xy_ff) - NB'(wz_ff);
      t2 = NB'(xz_ff) + NB'(wy_ff);
      t3 = NB'(xy_ff) + NB'(wz_ff);
      t5 = NB'(yz_ff) - NB'(wx_ff);
      t6 = NB'(xz_ff) - NB'(wy_ff);
      t7 = NB'(yz_ff) + NB'(wx_ff);
      s1 = split(t1);
      s2 = split(t2);
      s3 = split(t3);
      s5 = split(t5);
      s6 = split(t6);
      s7 = split(t7);
      num_in[E00] = {1'b0, yy_ff} + {1'b0, zz_ff};
      num_in[E11] = {1'b0, xx_ff} + {1'b0, zz_ff};
      num_in[E22] = {1'b0, xx_ff} + {1'b0, yy_ff};
      num_in[E01] = s1[NB-1:0];
      num_in[E02] = s2[NB-1:0];
      num_in[E10] = s3[NB-1:0];
      num_in[E12] = s5[NB-1:0];
      num_in[E20] = s6[NB-1:0];
      num_in[E21] = s7[NB-1:0];
      neg_in      = '0;
      neg_in[E01] = s1[NB];
      neg_in[E02] = s2[NB];
      neg_in[E10] = s3[NB];
      neg_in[E12] = s5[NB];
      neg_in[E20] = s6[NB];
      neg_in[E21] = s7[NB];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (!st2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!st2 && v1_ff) begin
         num_ff   <= num_in;
         neg_ff   <= neg_in;
         den_ff   <= den_in;
         zero2_ff <= zero1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign num       = num_ff;
   assign neg       = neg_ff;
   assign den       = den_ff;
   assign zero      = zero2_ff;

endmodule

### design/q2r_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2r_div
// Restoring division of the nine numerators by the squared norm, one
// quotient bit per pipeline stage, FB + 2 stages. The integer bit is
// settled in front of the first stage.
// ----------------------------------------------------------------------------
module q2r_div
   import q2r_pkg::*;
#(
   parameter int CB = 16,
   parameter int FB = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_stall,
   input  logic [NUM_ENTRIES-1:0][2*CB:0]       num,
   input  logic [NUM_ENTRIES-1:0]               neg,
   input  logic [2*CB:0]                        den,
   input  logic                                 zero,
   output logic                                 out_valid,
   input  logic                                 out_stall,
   output logic [NUM_ENTRIES-1:0][FB+2:0]       quo,
   output logic [NUM_ENTRIES-1:0]               quo_neg,
   output logic                                 quo_zero
);

   localparam int NB = 2 * CB + 1;
   localparam int S  = FB + 2;
   localparam int QW = FB + 3;
   localparam int L  = NUM_ENTRIES;

   logic                    vld [S+1];
   logic                    stl [S+1];
   logic [L-1:0][NB-1:0]    rem [S+1];
   logic [L-1:0][QW-1:0]    qv  [S+1];
   logic [L-1:0]            ngv [S+1];
   logic                    zrv [S+1];
   logic [NB-1:0]           dv  [S];

   // Settle the integer bit: a numerator never exceeds the norm
   always_comb begin
      for (int l = 0; l < L; l++) begin
         if (num[l] >= den) begin
            rem[0][l] = num[l] - den;
            qv[0][l]  = QW'(1);
         end else begin
            rem[0][l] = num[l];
            qv[0][l]  = '0;
         end
      end
   end

   assign vld[0]   = in_valid;
   assign ngv[0]   = neg;
   assign zrv[0]   = zero;
   assign dv[0]    = den;
   assign in_stall = stl[0];
   assign stl[S]   = out_stall;

   for (genvar k = 0; k < S; k++) begin : g_stage
      logic                 vld_ff;
      logic [L-1:0][NB-1:0] rem_ff, rem_in;
      logic [L-1:0][QW-1:0] quo_ff, quo_in;
      logic [L-1:0]         neg_ff;
      logic                 zero_ff;

      // Hold while the next stage holds
      assign stl[k] = vld[k+1] && stl[k+1];

      // One restoring step per lane
      always_comb begin
         logic [NB:0] two_r;
         for (int l = 0; l < L; l++) begin
            two_r = {rem[k][l], 1'b0};
            if (two_r >= {1'b0, dv[k]}) begin
               rem_in[l] = NB'(two_r - {1'b0, dv[k]});
               quo_in[l] = {qv[k][l][QW-2:0], 1'b1};
            end else begin
               rem_in[l] = NB'(two_r);
               quo_in[l] = {qv[k][l][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (!stl[k]) begin
            vld_ff <= vld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (!stl[k] && vld[k]) begin
            rem_ff  <= rem_in;
            quo_ff  <= quo_in;
            neg_ff  <= ngv[k];
            zero_ff <= zrv[k];
         end
      end

      assign vld[k+1] = vld_ff;
      assign rem[k+1] = rem_ff;
      assign qv[k+1]  = quo_ff;
      assign ngv[k+1] = neg_ff;
      assign zrv[k+1] = zero_ff;

      // Carry the divisor only to stages that still need it
      if (k < S - 1) begin : g_den
         logic [NB-1:0] den_ff;
         always_ff @(posedge clock) begin
            if (!stl[k] && vld[k]) begin
               den_ff <= dv[k];
            end
         end
         assign dv[k+1] = den_ff;
      end
   end

   assign out_valid = vld[S];
   assign quo       = qv[S];
   assign quo_neg   = ngv[S];
   assign quo_zero  = zrv[S];

endmodule

### design/q2r_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2r_round
// Output register: round the quotients half away from zero, apply sign or
// form one minus for the diagonal, saturate, and substitute the identity
// for an all-zero quaternion.
// ----------------------------------------------------------------------------
module q2r_round
   import q2r_pkg::*;
#(
   parameter int CB = 16,
   parameter int FB = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_stall,
   input  logic [NUM_ENTRIES-1:0][FB+2:0]       quo,
   input  logic [NUM_ENTRIES-1:0]               quo_neg,
   input  logic                                 quo_zero,
   output logic                                 out_valid,
   input  logic                                 out_stall,
   output logic [NUM_ENTRIES-1:0][CB-1:0]       entry,
   output logic                                 zero_error
);

   localparam int QW = FB + 3;
   localparam int RW = FB + 2;
   localparam int EW = ((FB + 3 > CB) ? FB + 3 : CB) + 1;

   localparam logic signed [EW-1:0] SAT_HI = {{(EW-CB+1){1'b0}}, {(CB-1){1'b1}}};
   localparam logic signed [EW-1:0] SAT_LO = {{(EW-CB+1){1'b1}}, {(CB-1){1'b0}}};
   localparam logic signed [EW-1:0] ONE    = EW'(1) << FB;

   logic                           valid_ff;
   logic [NUM_ENTRIES-1:0][CB-1:0] entry_ff, entry_in;
   logic                           zero_ff;

   // Clamp to the field range
   function automatic logic [CB-1:0] sat(input logic signed [EW-1:0] v);
      logic signed [EW-1:0] c;
      if (v > SAT_HI) begin
         c = SAT_HI;
      end else if (v < SAT_LO) begin
         c = SAT_LO;
      end else begin
         c = v;
      end
      return c[CB-1:0];
   endfunction

   assign in_stall = valid_ff && out_stall;

   always_comb begin
      logic [QW-1:0]        qp;
      logic [RW-1:0]        res;
      logic signed [EW-1:0] e;
      for (int l = 0; l < NUM_ENTRIES; l++) begin
         qp  = quo[l] + QW'(1);
         res = qp[QW-1:1];
         if (DIAG_MASK[l]) begin
            e = ONE - EW'(res);
         end else if (quo_neg[l]) begin
            e = -EW'(res);
         end else begin
            e = EW'(res);
         end
         if (quo_zero) begin
            e = DIAG_MASK[l] ? ONE : '0;
         end
         entry_in[l] = sat(e);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         entry_ff <= entry_in;
         zero_ff  <= quo_zero;
      end
   end

   assign out_valid  = valid_ff;
   assign entry      = entry_ff;
   assign zero_error = zero_ff;

endmodule

### design/quaternion_to_rotation_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Converts a fixed-point quaternion into the nine entries of its 3x3
// rotation matrix, scaled by 2 over the squared norm, saturated.
// ----------------------------------------------------------------------------
//   channel   ports                         direction  transfer when
//   request   req_valid req_stall req_q*    in         req_valid && !req_stall
//   response  rsp_valid rsp_stall rsp_r*    out        rsp_valid && !rsp_stall
//
// One transfer per cycle in each direction when not stalled.
// Pipeline stages in order: products, norm and numerators, FRACTION_BITS + 2
// divider stages, one rounding stage.
// Reset empties every stage; no state survives between quaternions.
// A stall holds only the stages that are full behind it; bubbles close up.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix
   import q2r_pkg::*;
#(
   parameter int COMPONENT_BITS = 16,
   parameter int FRACTION_BITS  = 14
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [COMPONENT_BITS-1:0] req_qx,
   input  logic signed [COMPONENT_BITS-1:0] req_qy,
   input  logic signed [COMPONENT_BITS-1:0] req_qz,
   input  logic signed [COMPONENT_BITS-1:0] req_qw,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [COMPONENT_BITS-1:0] rsp_r00,
   output logic signed [COMPONENT_BITS-1:0] rsp_r01,
   output logic signed [COMPONENT_BITS-1:0] rsp_r02,
   output logic signed [COMPONENT_BITS-1:0] rsp_r10,
   output logic signed [COMPONENT_BITS-1:0] rsp_r11,
   output logic signed [COMPONENT_BITS-1:0] rsp_r12,
   output logic signed [COMPONENT_BITS-1:0] rsp_r20,
   output logic signed [COMPONENT_BITS-1:0] rsp_r21,
   output logic signed [COMPONENT_BITS-1:0] rsp_r22,
   output logic                             rsp_zero_error
);

   localparam int CB = COMPONENT_BITS;
   localparam int FB = FRACTION_BITS;

   logic                            t_valid, t_stall, t_zero;
   logic [NUM_ENTRIES-1:0][2*CB:0]  t_num;
   logic [NUM_ENTRIES-1:0]          t_neg;
   logic [2*CB:0]                   t_den;
   logic                            d_valid, d_stall, d_zero;
   logic [NUM_ENTRIES-1:0][FB+2:0]  d_quo;
   logic [NUM_ENTRIES-1:0]          d_neg;
   logic [NUM_ENTRIES-1:0][CB-1:0]  entry;

   // Products, norm and numerators
   q2r_terms #(.CB(CB)) u_terms (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .qx        (req_qx),
      .qy        (req_qy),
      .qz        (req_qz),
      .qw        (req_qw),
      .out_valid (t_valid),
      .out_stall (t_stall),
      .num       (t_num),
      .neg       (t_neg),
      .den       (t_den),
      .zero      (t_zero)
   );

   // Bit-per-stage division by the norm
   q2r_div #(.CB(CB), .FB(FB)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t_valid),
      .in_stall  (t_stall),
      .num       (t_num),
      .neg       (t_neg),
      .den       (t_den),
      .zero      (t_zero),
      .out_valid (d_valid),
      .out_stall (d_stall),
      .quo       (d_quo),
      .quo_neg   (d_neg),
      .quo_zero  (d_zero)
   );

   // Round, saturate and register the result
   q2r_round #(.CB(CB), .FB(FB)) u_round (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (d_valid),
      .in_stall   (d_stall),
      .quo        (d_quo),
      .quo_neg    (d_neg),
      .quo_zero   (d_zero),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .entry      (entry),
      .zero_error (rsp_zero_error)
   );

   assign rsp_r00 = entry[E00];
   assign rsp_r01 = entry[E01];
   assign rsp_r02 = entry[E02];
   assign rsp_r10 = entry[E10];
   assign rsp_r11 = entry[E11];
   assign rsp_r12 = entry[E12];
   assign rsp_r20 = entry[E20];
   assign rsp_r21 = entry[E21];
   assign rsp_r22 = entry[E22];

endmodule
